// ----- rtl/core/suq_pkg.sv -----
package suq_pkg;

    localparam int MAX_SPHERES = 64;
    localparam int NUM_DIMS    = 3;

    localparam int IDX_W   = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W   = $clog2(MAX_SPHERES + 1);
    localparam int DIM_W   = 2;
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 2 * MAG_W + 2;
    localparam int ROOT_W  = 35;
    localparam int NUM_W   = MAG_W + RAD_W + 1;
    localparam int V_W     = NUM_W + 2;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [RAD_W-1:0]          sphere_radius;
    } item_t;

    typedef struct packed {
        logic                      is_inside;
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
        logic signed [COORD_W-1:0] proj_z;
        logic                      table_empty;
        logic                      table_full;
    } result_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_ADD,
        DP_CAPTURE,
        DP_READ,
        DP_SQ,
        DP_RSQ,
        DP_SQRT,
        DP_PICK,
        DP_PMUL,
        DP_PDIV,
        DP_PSTORE,
        DP_EMIT_Q,
        DP_EMIT_FULL,
        DP_EMIT_EMPTY
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [IDX_W-1:0] k;
        logic [DIM_W-1:0] dim;
        logic             first;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             out_free;
        logic             dist_zero;
    } dp_status_t;

endpackage

// ----- rtl/core/suq_ctrl.sv -----
module suq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           item_cmd,
    output logic                 item_ready,
    input  suq_pkg::dp_status_t  status,
    output suq_pkg::dp_cmd_t     dp_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ,
        ST_RSQ,
        ST_SQRT,
        ST_PICK,
        ST_PMUL,
        ST_PDIV,
        ST_PSTORE,
        ST_EMIT_Q,
        ST_EMIT_FULL,
        ST_EMIT_EMPTY
    } state_t;

    localparam logic [suq_pkg::DIM_W-1:0] LAST_DIM =
        suq_pkg::DIM_W'(suq_pkg::NUM_DIMS - 1);

    state_t                         state_reg, state_next;
    logic [suq_pkg::IDX_W-1:0]      k_reg, k_next;
    logic [suq_pkg::DIM_W-1:0]      dim_reg, dim_next;
    logic [suq_pkg::STEP_W-1:0]     step_reg, step_next;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        dim_next     = dim_reg;
        step_next    = step_reg;
        dp_cmd.op    = suq_pkg::DP_NOP;
        dp_cmd.k     = k_reg;
        dp_cmd.dim   = dim_reg;
        dp_cmd.first = 1'b0;
        item_ready   = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item_cmd)
                        suq_pkg::CMD_CLEAR:
                        begin
                            dp_cmd.op = suq_pkg::DP_CLEAR;
                        end
                        suq_pkg::CMD_ADD:
                        begin
                            if (status.count == suq_pkg::CNT_W'(suq_pkg::MAX_SPHERES))
                                state_next = ST_EMIT_FULL;
                            else
                                dp_cmd.op = suq_pkg::DP_ADD;
                        end
                        suq_pkg::CMD_QUERY:
                        begin
                            dp_cmd.op = suq_pkg::DP_CAPTURE;
                            k_next    = '0;
                            if (status.count == '0)
                                state_next = ST_EMIT_EMPTY;
                            else
                                state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                dp_cmd.op  = suq_pkg::DP_READ;
                dim_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                dp_cmd.op    = suq_pkg::DP_SQ;
                dp_cmd.first = (dim_reg == '0);
                if (dim_reg == LAST_DIM)
                    state_next = ST_RSQ;
                else
                    dim_next = dim_reg + suq_pkg::DIM_W'(1);
            end
            ST_RSQ:
            begin
                dp_cmd.op  = suq_pkg::DP_RSQ;
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                dp_cmd.op = suq_pkg::DP_SQRT;
                if (step_reg == suq_pkg::STEP_W'(suq_pkg::SQRT_STEPS - 1))
                    state_next = ST_PICK;
                else
                    step_next = step_reg + suq_pkg::STEP_W'(1);
            end
            ST_PICK:
            begin
                dp_cmd.op    = suq_pkg::DP_PICK;
                dp_cmd.first = (k_reg == '0);
                if (suq_pkg::CNT_W'(k_reg) + suq_pkg::CNT_W'(1) == status.count)
                begin
                    dim_next   = '0;
                    state_next = ST_PMUL;
                end
                else
                begin
                    k_next     = k_reg + suq_pkg::IDX_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_PMUL:
            begin
                dp_cmd.op = suq_pkg::DP_PMUL;
                step_next = '0;
                if (status.dist_zero)
                    state_next = ST_PSTORE;
                else
                    state_next = ST_PDIV;
            end
            ST_PDIV:
            begin
                dp_cmd.op = suq_pkg::DP_PDIV;
                if (step_reg == suq_pkg::STEP_W'(suq_pkg::DIV_STEPS - 1))
                    state_next = ST_PSTORE;
                else
                    step_next = step_reg + suq_pkg::STEP_W'(1);
            end
            ST_PSTORE:
            begin
                dp_cmd.op = suq_pkg::DP_PSTORE;
                if (dim_reg == LAST_DIM)
                    state_next = ST_EMIT_Q;
                else
                begin
                    dim_next   = dim_reg + suq_pkg::DIM_W'(1);
                    state_next = ST_PMUL;
                end
            end
            ST_EMIT_Q:
            begin
                if (status.out_free)
                begin
                    dp_cmd.op  = suq_pkg::DP_EMIT_Q;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_FULL:
            begin
                if (status.out_free)
                begin
                    dp_cmd.op  = suq_pkg::DP_EMIT_FULL;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_EMPTY:
            begin
                if (status.out_free)
                begin
                    dp_cmd.op  = suq_pkg::DP_EMIT_EMPTY;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            dim_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            dim_reg   <= dim_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/core/suq_dp.sv -----
module suq_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  suq_pkg::item_t       item,
    input  suq_pkg::dp_cmd_t     dp_cmd,
    output suq_pkg::dp_status_t  status,
    input  logic                 result_ready,
    output logic                 result_valid,
    output suq_pkg::result_t     result
);

    typedef struct packed {
        logic signed [suq_pkg::COORD_W-1:0] cx;
        logic signed [suq_pkg::COORD_W-1:0] cy;
        logic signed [suq_pkg::COORD_W-1:0] cz;
        logic [suq_pkg::RAD_W-1:0]          r;
    } sphere_t;

    localparam int CW  = suq_pkg::COORD_W;
    localparam int RW  = suq_pkg::ROOT_W;
    localparam int NW  = suq_pkg::NUM_W;
    localparam int VW  = suq_pkg::V_W;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sph_coord(sphere_t s, logic [1:0] d);
        case (d)
            2'd0:    return s.cx;
            2'd1:    return s.cy;
            default: return s.cz;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] sat_v(logic signed [VW-1:0] v);
        if (v > VW'(CMAX))
            return CMAX;
        else if (v < VW'(CMIN))
            return CMIN;
        else
            return v[CW-1:0];
    endfunction

    sphere_t                              mem [suq_pkg::MAX_SPHERES];
    sphere_t                              rd_reg;
    sphere_t                              best_reg;
    logic signed [CW-1:0]                 pt_reg [3];
    logic signed [CW-1:0]                 proj_reg [3];
    logic signed [CW-1:0]                 box_lo_reg [3];
    logic signed [CW-1:0]                 box_hi_reg [3];
    logic [suq_pkg::CNT_W-1:0]            count_reg;
    logic                                 inside_reg;
    logic                                 in_box_reg;
    logic                                 out_valid_reg;
    suq_pkg::result_t                     result_reg;
    logic [suq_pkg::SQ_W-1:0]             acc_reg;
    logic [2*RW-1:0]                      src_reg;
    logic [RW-1:0]                        root_reg;
    logic [RW+1:0]                        rem_reg;
    logic [RW-1:0]                        best_dev_reg;
    logic [RW-1:0]                        best_dist_reg;
    logic [NW-1:0]                        quo_reg;
    logic [RW:0]                          drem_reg;
    logic                                 neg_reg;

    // shared difference / magnitude
    sphere_t                              diff_src;
    logic signed [CW-1:0]                 pt_sel;
    logic signed [CW-1:0]                 c_sel;
    logic signed [CW:0]                   diff;
    logic [CW:0]                          diff_neg;
    logic [suq_pkg::MAG_W-1:0]            mag;
    logic [2*suq_pkg::MAG_W-1:0]          sq;
    logic [2*suq_pkg::RAD_W-1:0]          r2;
    logic [RW+3:0]                        rem_sh;
    logic [RW+3:0]                        trial;
    logic                                 sq_ge;
    logic [RW-1:0]                        rad_ext;
    logic [RW-1:0]                        dev;
    logic [suq_pkg::MAG_W+suq_pkg::RAD_W-1:0] prod;
    logic [RW+1:0]                        dt;
    logic                                 d_ge;
    logic signed [VW-1:0]                 v;
    logic                                 in_box_now;
    logic signed [CW:0]                   lo_w [3];
    logic signed [CW:0]                   hi_w [3];
    logic signed [CW-1:0]                 lo_s [3];
    logic signed [CW-1:0]                 hi_s [3];
    logic signed [CW-1:0]                 it_c [3];

    always_comb
    begin
        it_c[0] = item.coord_x;
        it_c[1] = item.coord_y;
        it_c[2] = item.coord_z;

        diff_src = (dp_cmd.op == suq_pkg::DP_SQ) ? rd_reg : best_reg;
        case (dp_cmd.dim)
            2'd0:    pt_sel = pt_reg[0];
            2'd1:    pt_sel = pt_reg[1];
            default: pt_sel = pt_reg[2];
        endcase
        c_sel    = sph_coord(diff_src, dp_cmd.dim);
        diff     = {pt_sel[CW-1], pt_sel} - {c_sel[CW-1], c_sel};
        diff_neg = (CW+1)'(0) - diff;
        mag      = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];
        sq       = mag * mag;
        r2       = rd_reg.r * rd_reg.r;

        // one digit pair of the restoring square root
        rem_sh = {rem_reg, src_reg[2*RW-1 -: 2]};
        trial  = (RW+4)'({root_reg, 2'b01});
        sq_ge  = (rem_sh >= trial);

        rad_ext = RW'(rd_reg.r);
        dev     = (root_reg > rad_ext) ? root_reg - rad_ext : rad_ext - root_reg;

        prod = mag * best_reg.r;

        // one bit of the restoring divider
        dt   = {drem_reg, quo_reg[NW-1]};
        d_ge = (dt >= (RW+2)'(best_dist_reg));

        if (best_dist_reg == '0)
            v = VW'(c_sel) + ((dp_cmd.dim == 2'd0) ? VW'(best_reg.r) : VW'(0));
        else if (neg_reg)
            v = VW'(c_sel) - VW'(quo_reg);
        else
            v = VW'(c_sel) + VW'(quo_reg);

        in_box_now = 1'b1;
        for (int d = 0; d < 3; d++)
        begin
            if (d < suq_pkg::NUM_DIMS)
            begin
                if (it_c[d] < box_lo_reg[d] || box_hi_reg[d] < it_c[d])
                    in_box_now = 1'b0;
            end
            lo_w[d] = {it_c[d][CW-1], it_c[d]} - (CW+1)'(item.sphere_radius);
            hi_w[d] = {it_c[d][CW-1], it_c[d]} + (CW+1)'(item.sphere_radius);
            lo_s[d] = (lo_w[d] < (CW+1)'(CMIN)) ? CMIN : lo_w[d][CW-1:0];
            hi_s[d] = (hi_w[d] > (CW+1)'(CMAX)) ? CMAX : hi_w[d][CW-1:0];
        end
    end

    // control state and box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            inside_reg    <= 1'b0;
            in_box_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < 3; d++)
            begin
                box_lo_reg[d] <= CMAX;
                box_hi_reg[d] <= CMIN;
            end
        end
        else
        begin
            if (dp_cmd.op inside {suq_pkg::DP_EMIT_Q, suq_pkg::DP_EMIT_FULL,
                                  suq_pkg::DP_EMIT_EMPTY})
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            case (dp_cmd.op)
                suq_pkg::DP_CLEAR:
                begin
                    count_reg <= '0;
                    for (int d = 0; d < 3; d++)
                    begin
                        box_lo_reg[d] <= CMAX;
                        box_hi_reg[d] <= CMIN;
                    end
                end
                suq_pkg::DP_ADD:
                begin
                    count_reg <= count_reg + suq_pkg::CNT_W'(1);
                    for (int d = 0; d < suq_pkg::NUM_DIMS; d++)
                    begin
                        if (lo_s[d] < box_lo_reg[d])
                            box_lo_reg[d] <= lo_s[d];
                        if (hi_s[d] > box_hi_reg[d])
                            box_hi_reg[d] <= hi_s[d];
                    end
                end
                suq_pkg::DP_CAPTURE:
                begin
                    inside_reg <= 1'b0;
                    in_box_reg <= in_box_now;
                end
                suq_pkg::DP_RSQ:
                begin
                    if (in_box_reg && acc_reg < suq_pkg::SQ_W'(r2))
                        inside_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // sphere table
    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == suq_pkg::DP_ADD)
            mem[count_reg[suq_pkg::IDX_W-1:0]] <= '{cx: item.coord_x, cy: item.coord_y,
                                                    cz: item.coord_z, r: item.sphere_radius};
        if (dp_cmd.op == suq_pkg::DP_READ)
            rd_reg <= mem[dp_cmd.k];
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        case (dp_cmd.op)
            suq_pkg::DP_CAPTURE:
            begin
                for (int d = 0; d < 3; d++)
                begin
                    pt_reg[d]   <= it_c[d];
                    proj_reg[d] <= '0;
                end
            end
            suq_pkg::DP_SQ:
            begin
                acc_reg <= (dp_cmd.first ? suq_pkg::SQ_W'(0) : acc_reg) + suq_pkg::SQ_W'(sq);
            end
            suq_pkg::DP_RSQ:
            begin
                src_reg  <= (2*RW)'(acc_reg);
                root_reg <= '0;
                rem_reg  <= '0;
            end
            suq_pkg::DP_SQRT:
            begin
                src_reg  <= {src_reg[2*RW-3:0], 2'b00};
                root_reg <= {root_reg[RW-2:0], sq_ge};
                rem_reg  <= sq_ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
            end
            suq_pkg::DP_PICK:
            begin
                if (dp_cmd.first || dev < best_dev_reg)
                begin
                    best_dev_reg  <= dev;
                    best_dist_reg <= root_reg;
                    best_reg      <= rd_reg;
                end
            end
            suq_pkg::DP_PMUL:
            begin
                quo_reg  <= NW'(prod) + NW'(best_dist_reg >> 1);
                drem_reg <= '0;
                neg_reg  <= diff[CW];
            end
            suq_pkg::DP_PDIV:
            begin
                quo_reg  <= {quo_reg[NW-2:0], d_ge};
                drem_reg <= d_ge ? (RW+1)'(dt - (RW+2)'(best_dist_reg)) : (RW+1)'(dt);
            end
            suq_pkg::DP_PSTORE:
            begin
                case (dp_cmd.dim)
                    2'd0:    proj_reg[0] <= sat_v(v);
                    2'd1:    proj_reg[1] <= sat_v(v);
                    default: proj_reg[2] <= sat_v(v);
                endcase
            end
            suq_pkg::DP_EMIT_Q:
            begin
                result_reg <= '{is_inside: inside_reg, proj_x: proj_reg[0],
                                proj_y: proj_reg[1], proj_z: proj_reg[2],
                                table_empty: 1'b0, table_full: 1'b0};
            end
            suq_pkg::DP_EMIT_FULL:
            begin
                result_reg <= '{is_inside: 1'b0, proj_x: '0, proj_y: '0, proj_z: '0,
                                table_empty: 1'b0, table_full: 1'b1};
            end
            suq_pkg::DP_EMIT_EMPTY:
            begin
                result_reg <= '{is_inside: 1'b0, proj_x: '0, proj_y: '0, proj_z: '0,
                                table_empty: 1'b1, table_full: 1'b0};
            end
            default: ;
        endcase
    end

    assign status.count     = count_reg;
    assign status.out_free  = !out_valid_reg || result_ready;
    assign status.dist_zero = (best_dist_reg == '0);
    assign result_valid     = out_valid_reg;
    assign result           = result_reg;

endmodule

// ----- rtl/core/sphere_union_point_query.sv -----
// Channel   Signals                              Direction  Transaction
// item      item_valid / item_ready / item       in         clear, add sphere or query point
// result    result_valid / result_ready / result out        one answer per query or dropped add
//
// Clear and a stored add complete without leaving the idle state. A query with N
// stored spheres runs, per sphere, a table read, three squaring steps, one radius
// square and a 35-step digit-pair square root; then per axis a multiply and a
// 64-step restoring divide (skipped when the point sits on the chosen centre).
// Reset is asynchronous active low; it empties the table and resets the box. The
// sphere table itself is not cleared, only entries below the count are ever read.
// A waiting result stalls a finished query but the next transaction is accepted
// while the result register is still full.
module sphere_union_point_query (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  suq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output suq_pkg::result_t result
);

    suq_pkg::dp_cmd_t    dp_cmd;
    suq_pkg::dp_status_t dp_status;

    // sequencer: walks the table, then the axes of the projection
    suq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_ready (item_ready),
        .status     (dp_status),
        .dp_cmd     (dp_cmd)
    );

    // table, box, multipliers, root and divider, result register
    suq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .dp_cmd       (dp_cmd),
        .status       (dp_status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dp_status.count <= suq_pkg::CNT_W'(suq_pkg::MAX_SPHERES))
        else $error("sphere count past table depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == suq_pkg::DP_EMIT_Q || dp_cmd.op == suq_pkg::DP_EMIT_FULL ||
         dp_cmd.op == suq_pkg::DP_EMIT_EMPTY) |-> dp_status.out_free)
        else $error("result overwritten before transaction");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.table_empty) |->
        (!result.is_inside && result.proj_x == '0 && result.proj_y == '0 &&
         result.proj_z == '0 && !result.table_full))
        else $error("empty-table result carries data");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.cmd == suq_pkg::CMD_CLEAR) |=>
        (dp_status.count == '0))
        else $error("clear did not empty table");

endmodule

// ----- tb/tb_sphere_union_point_query.sv -----
`timescale 1ns / 100ps

module tb_sphere_union_point_query;

    // Opcode 3 is not decoded by the block; it must be swallowed silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam logic [suq_pkg::RAD_W-1:0] RAD_MAX = {suq_pkg::RAD_W{1'b1}};

    // Worst quiet stretch: a full-table query stacked on the long receiver
    // hold-off, with plenty of margin on top.
    localparam int WD_LIMIT   = 20000;
    localparam int HOLD_OFF   = 1500;
    localparam int DRAIN_WAIT = 3000;

    // Sphere table predictor plus the queue of answers still owed by the block.
    class sphere_scoreboard;
        longint ctr[suq_pkg::MAX_SPHERES][3];
        longint rad[suq_pkg::MAX_SPHERES];
        int     count;
        longint box_lo[3];
        longint box_hi[3];
        suq_pkg::result_t answers_due[$];
        int     errors;

        function new();
            count  = 0;
            errors = 0;
            clear_box();
        endfunction

        function void clear_box();
            for (int d = 0; d < 3; d++)
            begin
                box_lo[d] = S32_MAX;
                box_hi[d] = S32_MIN;
            end
        endfunction

        function longint sat32(longint v);
            if (v > S32_MAX)
                return S32_MAX;
            if (v < S32_MIN)
                return S32_MIN;
            return v;
        endfunction

        function void owe_answer(suq_pkg::result_t a);
            answers_due = {answers_due, a};
        endfunction

        // Accepted input transaction: update the table and owe an answer if any.
        function void note_item(suq_pkg::item_t it);
            longint     p[3];
            longint     proj[3];
            longint     diff;
            logic [63:0]  mag;
            logic [127:0] sq, r2, root, dev, best_dev, best_dist, cand, q;
            logic       hit, in_box, found;
            int         best;
            suq_pkg::result_t ans;

            p[0] = it.coord_x;
            p[1] = it.coord_y;
            p[2] = it.coord_z;
            ans  = '0;
            case (it.cmd)
                suq_pkg::CMD_CLEAR:
                begin
                    count = 0;
                    clear_box();
                end
                suq_pkg::CMD_ADD:
                begin
                    if (count >= suq_pkg::MAX_SPHERES)
                    begin
                        ans.table_full = 1'b1;
                        owe_answer(ans);
                    end
                    else
                    begin
                        for (int d = 0; d < 3; d++)
                            ctr[count][d] = p[d];
                        rad[count] = longint'(it.sphere_radius);
                        for (int d = 0; d < suq_pkg::NUM_DIMS && d < 3; d++)
                        begin
                            if (sat32(p[d] - rad[count]) < box_lo[d])
                                box_lo[d] = sat32(p[d] - rad[count]);
                            if (sat32(p[d] + rad[count]) > box_hi[d])
                                box_hi[d] = sat32(p[d] + rad[count]);
                        end
                        count++;
                    end
                end
                suq_pkg::CMD_QUERY:
                begin
                    hit       = 1'b0;
                    in_box    = 1'b1;
                    found     = 1'b0;
                    best      = 0;
                    best_dev  = '0;
                    best_dist = '0;
                    for (int d = 0; d < suq_pkg::NUM_DIMS && d < 3; d++)
                        if (p[d] < box_lo[d] || box_hi[d] < p[d])
                            in_box = 1'b0;
                    for (int k = 0; k < count; k++)
                    begin
                        sq = '0;
                        for (int d = 0; d < suq_pkg::NUM_DIMS && d < 3; d++)
                        begin
                            diff = p[d] - ctr[k][d];
                            mag  = (diff < 0) ? -diff : diff;
                            sq   = sq + {64'd0, mag} * {64'd0, mag};
                        end
                        r2 = {64'd0, rad[k]} * {64'd0, rad[k]};
                        if (in_box && sq < r2)
                            hit = 1'b1;
                        // floor square root, bit by bit from 2^34 down
                        root = '0;
                        for (int b = 34; b >= 0; b--)
                        begin
                            cand = root | (128'd1 << b);
                            if (cand * cand <= sq)
                                root = cand;
                        end
                        dev = (root > rad[k]) ? root - rad[k] : rad[k] - root;
                        // strict compare: earliest sphere keeps a tie
                        if (!found || dev < best_dev)
                        begin
                            found     = 1'b1;
                            best_dev  = dev;
                            best_dist = root;
                            best      = k;
                        end
                    end
                    if (!found)
                        ans.table_empty = 1'b1;
                    else
                    begin
                        for (int d = 0; d < 3; d++)
                            proj[d] = 0;
                        for (int d = 0; d < suq_pkg::NUM_DIMS && d < 3; d++)
                        begin
                            if (best_dist == 0)
                                proj[d] = sat32(ctr[best][d] + ((d == 0) ? rad[best] : 0));
                            else
                            begin
                                diff = p[d] - ctr[best][d];
                                mag  = (diff < 0) ? -diff : diff;
                                q    = ({64'd0, mag} * {64'd0, rad[best]} + best_dist / 2)
                                       / best_dist;
                                proj[d] = sat32((diff < 0) ? ctr[best][d] - longint'(q)
                                                           : ctr[best][d] + longint'(q));
                            end
                        end
                        ans.is_inside = hit;
                        ans.proj_x    = proj[0][31:0];
                        ans.proj_y    = proj[1][31:0];
                        ans.proj_z    = proj[2][31:0];
                    end
                    owe_answer(ans);
                end
                default: ;
            endcase
        endfunction

        function void cmp_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act)
            begin
                $error("%s: expected %h, got %h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_answer(suq_pkg::result_t got);
            suq_pkg::result_t exp;
            if (answers_due.size() == 0)
            begin
                $error("result transaction with no answer outstanding");
                errors++;
                return;
            end
            exp = answers_due.pop_front();
            cmp_field("is_inside",   exp.is_inside,   got.is_inside);
            cmp_field("proj_x",      exp.proj_x,      got.proj_x);
            cmp_field("proj_y",      exp.proj_y,      got.proj_y);
            cmp_field("proj_z",      exp.proj_z,      got.proj_z);
            cmp_field("table_empty", exp.table_empty, got.table_empty);
            cmp_field("table_full",  exp.table_full,  got.table_full);
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    suq_pkg::item_t   item;
    logic    result_valid;
    logic    result_ready;
    suq_pkg::result_t result;

    sphere_scoreboard sb;
    int   tx_idle;        // percent of cycles the sender sits out
    int   rx_idle;        // percent of cycles the receiver stalls
    bit   hold_req;       // asks the receiver for one long hold-off
    int   quiet_cycles;

    sphere_union_point_query dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Both sides are observed at the edge using pre-edge values, so the
    // predictor sees every accepted transaction in acceptance order.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            sb.note_item(item);
        if (rst_n && result_valid && result_ready)
            sb.check_answer(result);
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request so the
    // result register backs up and the input side stalls.
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            result_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    function automatic suq_pkg::item_t mk(logic [1:0] cmd, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [suq_pkg::RAD_W-1:0] r);
        suq_pkg::item_t it;
        it.cmd           = cmd;
        it.coord_x       = x;
        it.coord_y       = y;
        it.coord_z       = z;
        it.sphere_radius = r;
        return it;
    endfunction

    function automatic logic [suq_pkg::RAD_W-1:0] rand_rad();
        return suq_pkg::RAD_W'($urandom());
    endfunction

    function automatic logic [31:0] rand_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return $urandom_range(1 << 19) - (1 << 18);   // cluster near origin
        if (sel < 85)
            return $urandom();
        case ($urandom_range(2))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            default: return 32'h0;
        endcase
    endfunction

    function automatic suq_pkg::item_t rand_add();
        logic [suq_pkg::RAD_W-1:0] r;
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            r = suq_pkg::RAD_W'($urandom_range(1 << 18));
        else if (sel < 80)
            r = rand_rad();
        else if (sel < 90)
            r = '0;
        else
            r = RAD_MAX;
        return mk(suq_pkg::CMD_ADD, rand_coord(), rand_coord(), rand_coord(), r);
    endfunction

    // Query points mostly land on or around a stored sphere.
    function automatic suq_pkg::item_t rand_query();
        int     k;
        int     sel;
        longint span;
        longint v[3];
        sel = $urandom_range(99);
        if (sb.count > 0 && sel < 60)
        begin
            k    = $urandom_range(sb.count - 1);
            span = (sb.rad[k] < (1 << 20)) ? sb.rad[k] + 16 : (1 << 20);
            for (int d = 0; d < 3; d++)
            begin
                v[d] = sb.ctr[k][d];
                if (sel >= 12)
                    v[d] = sb.sat32(v[d] + longint'($urandom_range(2 * span)) - span);
            end
            return mk(suq_pkg::CMD_QUERY, v[0][31:0], v[1][31:0], v[2][31:0], rand_rad());
        end
        return mk(suq_pkg::CMD_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_rad());
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send(suq_pkg::item_t it);
        while ($urandom_range(99) < tx_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Walk the table past capacity so dropped adds and full-table queries occur.
    task automatic fill_table();
        send(mk(suq_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(), rand_rad()));
        repeat (suq_pkg::MAX_SPHERES + 2) send(rand_add());
        repeat (2) send(rand_query());
        send(mk(suq_pkg::CMD_CLEAR, '0, '0, '0, '0));
    endtask

    task automatic random_phase(int n);
        int sel;
        fill_table();
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 6 || (sel < 40 && sb.count > 10))
                send(mk(suq_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom(), rand_rad()));
            else if (sel < 10)
                send(mk(CMD_UNUSED, $urandom(), $urandom(), $urandom(), rand_rad()));
            else if (sel < 40)
                send(rand_add());
            else
                send(rand_query());
        end
    endtask

    initial
    begin
        sb           = new();
        hold_req     = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        tx_idle      = 10;
        rx_idle      = 49;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, centre hit, ties, saturation, extremes, opcode 3.
        send(mk(suq_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0, '0));
        send(mk(suq_pkg::CMD_ADD, 32'h0, 32'h0, 32'h0, 31'h1_0000));
        send(mk(suq_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h8000, 32'h0, 32'h0, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h1_0000, 32'h0, 32'h0, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, RAD_MAX));
        send(mk(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, RAD_MAX));
        send(mk(suq_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0, '0));
        // equidistant pair along x: the first one must win
        send(mk(suq_pkg::CMD_ADD, 32'hffff_0000, 32'h0, 32'h0, 31'h8000));
        send(mk(suq_pkg::CMD_ADD, 32'h0001_0000, 32'h0, 32'h0, 31'h8000));
        send(mk(suq_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h0, 32'h4000, 32'hffff_c000, '0));
        send(mk(suq_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0, '0));
        // huge spheres at the corners of the coordinate range
        send(mk(suq_pkg::CMD_ADD, 32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_fff0, RAD_MAX));
        send(mk(suq_pkg::CMD_QUERY, 32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_fff0, '0));
        send(mk(suq_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, RAD_MAX));
        send(mk(suq_pkg::CMD_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'h0, '0));
        send(mk(suq_pkg::CMD_ADD, 32'h0, 32'h0, 32'h0, '0));
        send(mk(suq_pkg::CMD_QUERY, 32'h10, 32'hffff_fff0, 32'h0, '0));

        random_phase(160);
        tx_idle = 49;
        rx_idle = 10;
        random_phase(160);
        tx_idle  = 0;
        rx_idle  = 0;
        hold_req = 1'b1;
        random_phase(160);
        item_valid <= 1'b0;

        while (sb.answers_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.answers_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sphere_union_point_query.f -----
rtl/core/suq_pkg.sv
rtl/core/suq_ctrl.sv
rtl/core/suq_dp.sv
rtl/core/sphere_union_point_query.sv
tb/tb_sphere_union_point_query.sv
